// File: rtl/rpac_pkg.sv
// Shared types, constants and helper functions for the rate PID axis controller.
// No dependencies; the controller, its register file, multiplier and testbench import this package.
package rpac_pkg;

    // Axis slots and fixed-point format
    localparam int AXIS_COUNT   = 3;
    localparam int FRAC_BITS    = 16;
    localparam int GAIN_SLOTS   = 3;
    localparam int AXIS_IDX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int AXIS_LIMIT_I = (AXIS_COUNT < GAIN_SLOTS) ? AXIS_COUNT : GAIN_SLOTS;
    localparam logic [2:0] AXIS_LIMIT  = 3'(AXIS_LIMIT_I);
    localparam logic [1:0] SCALED_AXES = 2'd2;

    // Axis codes
    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DFAC  = 3'd6;

    localparam logic [47:0] RST_OUT_LIMITS      = 48'd70370891694080;
    localparam logic [47:0] RST_INTEGRAL_LIMITS = 48'd70369173707162;
    localparam logic [31:0] RST_STEP            = 32'd4294967;
    localparam logic [31:0] RST_DFAC            = 32'd209715;

    typedef struct packed {
        logic [47:0] kp_gains;
        logic [47:0] ki_gains;
        logic [47:0] kd_gains;
        logic [47:0] out_limits;
        logic [47:0] integral_limits;
        logic [31:0] integration_step;
        logic [31:0] derivative_factor;
    } t_cfg;

    // Shared multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [PROD_W-1:0]  t_prod;

    // Scaling constants
    localparam logic [15:0] ONE_Q14   = 16'd16384;
    localparam int          TENTH_Q20 = 104858;
    localparam int          LIM_SHIFT = 30 - FRAC_BITS;

    localparam t_prod INT32_MAX_P = t_prod'(32'sh7FFF_FFFF);
    localparam t_prod INT32_MIN_P = -t_prod'(32'sh7FFF_FFFF) - t_prod'(1);

    function automatic logic signed [31:0] sat32(input t_prod v);
        logic signed [31:0] r;
        if (v > INT32_MAX_P) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < INT32_MIN_P) begin
            r = 32'sh8000_0000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

    function automatic logic [15:0] slot16(input logic [47:0] r, input logic [1:0] ax);
        logic [15:0] s;
        case (ax)
            AX_ROLL:  s = r[15:0];
            AX_PITCH: s = r[31:16];
            AX_YAW:   s = r[47:32];
            default:  s = '0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/rpac_cfg.sv
// Configuration register file of the rate PID axis controller.
// Depends on rpac_pkg for register codes, reset values and the t_cfg struct.
module rpac_cfg import rpac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gains          <= '0;
            r_cfg.ki_gains          <= '0;
            r_cfg.kd_gains          <= '0;
            r_cfg.out_limits        <= RST_OUT_LIMITS;
            r_cfg.integral_limits   <= RST_INTEGRAL_LIMITS;
            r_cfg.integration_step  <= RST_STEP;
            r_cfg.derivative_factor <= RST_DFAC;
        end else if (i_we) begin
            case (i_idx)
                CFG_KP:   r_cfg.kp_gains          <= i_data;
                CFG_KI:   r_cfg.ki_gains          <= i_data;
                CFG_KD:   r_cfg.kd_gains          <= i_data;
                CFG_OLIM: r_cfg.out_limits        <= i_data;
                CFG_ILIM: r_cfg.integral_limits   <= i_data;
                CFG_STEP: r_cfg.integration_step  <= i_data[31:0];
                CFG_DFAC: r_cfg.derivative_factor <= i_data[31:0];
                default:  ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/rpac_mul.sv
// Shared signed multiplier with a registered product.
// Depends on rpac_pkg for the operand and product types.
module rpac_mul import rpac_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_mul_a i_a,
    input  t_mul_b i_b,
    output t_prod  o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/rate_pid_axis_controller.sv
// Rate PID axis controller: handshakes, sequencer, datapath and per-axis state.
// Depends on rpac_pkg, rpac_cfg and rpac_mul.
//
// One word in gives one word out. Each word names an axis (roll, pitch or yaw)
// and carries the rate error, the filtered gyro rate, an on-ground flag, a
// battery scale and P and D gain scales (the gain scales apply to roll and
// pitch only). A word is taken only while the sequencer is idle; it then runs
// eleven products through one shared 34 x 33 bit multiplier, each product consumed
// the step after it is issued; the next word is taken only once the sequencer has
// passed its final step, which needs the result register to be free. A word naming
// an axis with no slot goes straight to that final step, returns all-zero fields and
// leaves the state untouched. A finished result waits
// in the output register while the next word is accepted and worked on; only the
// last step stalls if that result is still not taken. Configuration writes go
// straight into the register file and must only be issued while the block is idle.
// Reset clears the integrators, the last drive and the rate history of every axis.
module rate_pid_axis_controller import rpac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_axis,
    input  logic signed [31:0]    i_rate_error,
    input  logic signed [31:0]    i_filtered_rate,
    input  logic                  i_on_ground,
    input  logic [15:0]           i_battery_scale,
    input  logic [15:0]           i_p_gain_scale,
    input  logic [15:0]           i_d_gain_scale,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_drive,
    output logic signed [31:0]    o_p_part,
    output logic signed [31:0]    o_i_part,
    output logic signed [31:0]    o_d_part,
    output logic                  o_windup_hold
);

    // Sequencer states: each C<n> may issue a product and consume the one issued in C<n-1>
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_C0   = 4'd1;
    localparam logic [3:0] ST_C1   = 4'd2;
    localparam logic [3:0] ST_C2   = 4'd3;
    localparam logic [3:0] ST_C3   = 4'd4;
    localparam logic [3:0] ST_C4   = 4'd5;
    localparam logic [3:0] ST_C5   = 4'd6;
    localparam logic [3:0] ST_C6   = 4'd7;
    localparam logic [3:0] ST_C7   = 4'd8;
    localparam logic [3:0] ST_C8   = 4'd9;
    localparam logic [3:0] ST_C9   = 4'd10;
    localparam logic [3:0] ST_C10  = 4'd11;
    localparam logic [3:0] ST_C11  = 4'd12;
    localparam logic [3:0] ST_C12  = 4'd13;
    localparam logic [3:0] ST_C13  = 4'd14;
    localparam logic [3:0] ST_FIN  = 4'd15;

    // Rounding offsets (half an LSB of each shift)
    localparam t_prod LIM_RND  = t_prod'(1) <<< (LIM_SHIFT - 1);
    localparam t_prod KIS_RND  = t_prod'(1) <<< 19;
    localparam t_prod TERM_RND = t_prod'(1) <<< 23;
    localparam t_prod GAIN_RND = t_prod'(1) <<< 21;
    localparam t_prod G_RND    = t_prod'(1) <<< 9;
    localparam t_prod DG_RND   = t_prod'(1) <<< 15;
    localparam t_prod D_RND    = t_prod'(1) <<< 16;
    localparam t_prod DRV_RND  = t_prod'(1) <<< 13;
    localparam t_mul_b TENTH_B = t_mul_b'(TENTH_Q20);

    t_cfg  w_cfg;
    t_prod w_prod;
    t_mul_a w_mul_a;
    t_mul_b w_mul_b;
    logic  w_mul_en;

    logic [3:0] r_state, n_state;
    logic       w_in_fire, w_out_fire, w_out_room, w_axis_ok;

    // Latched word
    logic [1:0]         r_axis;
    logic signed [31:0] r_err, r_rate;
    logic               r_ground, r_null;
    logic [15:0]        r_bat, r_ps, r_ds;

    // Intermediate results
    logic [31:0]        r_olim, r_ilim, r_tmp;
    logic [27:0]        r_kis;
    logic [26:0]        r_gain;
    logic [21:0]        r_g;
    logic [30:0]        r_dg;
    logic               r_hold, r_kd_nz;
    logic signed [37:0] r_integ_raw;
    logic signed [31:0] r_integ, r_p, r_d;
    logic signed [32:0] r_ndiff, r_pi;
    logic signed [33:0] r_sum;

    // Per-axis state
    logic signed [31:0] r_integ_acc  [AXIS_COUNT];
    logic signed [31:0] r_prev_drive [AXIS_COUNT];
    logic signed [31:0] r_hist0      [AXIS_COUNT];
    logic signed [31:0] r_hist1      [AXIS_COUNT];

    // Output register
    logic               r_out_valid, r_out_hold;
    logic signed [31:0] r_out_drive, r_out_p, r_out_i, r_out_d;

    logic [AXIS_IDX_W-1:0] w_ax;
    logic [15:0]  w_kp, w_ki, w_kd, w_olim_s, w_ilim_s;
    t_prod        w_lim_full, w_kis_full, w_delta, w_gain_full, w_g_full;
    t_prod        w_p_full, w_dg_full, w_d_full, w_drv_full, w_drv_lim;
    logic signed [33:0] w_prev34, w_olim34;
    logic signed [37:0] w_base, w_ilim38, w_integ_clamp;
    logic               w_hold;
    logic signed [31:0] w_drive;

    rpac_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    rpac_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    assign w_out_room = !r_out_valid || i_out_ready;
    assign w_axis_ok  = {1'b0, i_axis} < AXIS_LIMIT;
    assign o_in_ready = (r_state == ST_IDLE);

    assign w_ax     = r_axis[AXIS_IDX_W-1:0];
    assign w_kp     = slot16(w_cfg.kp_gains, r_axis);
    assign w_ki     = slot16(w_cfg.ki_gains, r_axis);
    assign w_kd     = slot16(w_cfg.kd_gains, r_axis);
    assign w_olim_s = slot16(w_cfg.out_limits, r_axis);
    assign w_ilim_s = slot16(w_cfg.integral_limits, r_axis);

    // Round-and-shift of the registered product, one view per consumer
    assign w_lim_full  = (w_prod + LIM_RND) >>> LIM_SHIFT;
    assign w_kis_full  = (w_prod + KIS_RND) >>> 20;
    assign w_delta     = (w_prod + TERM_RND) >>> 24;
    assign w_gain_full = (w_prod + GAIN_RND) >>> 22;
    assign w_g_full    = (w_prod + G_RND) >>> 10;
    assign w_p_full    = (w_prod + TERM_RND) >>> 24;
    assign w_dg_full   = (w_prod + DG_RND) >>> 16;
    assign w_d_full    = (w_prod + D_RND) >>> 17;
    assign w_drv_full  = (w_prod + DRV_RND) >>> 14;

    // Freeze the integrator when the last drive sat at the limit and the
    // error pushes further into it
    assign w_prev34 = {{2{r_prev_drive[w_ax][31]}}, r_prev_drive[w_ax]};
    assign w_olim34 = $signed({2'b00, r_olim});
    assign w_hold   = ((w_prev34 >= w_olim34) && (r_err > 32'sd0)) ||
                      ((w_prev34 <= -w_olim34) && (r_err < 32'sd0));

    assign w_base   = r_ground ? '0 : {{6{r_integ_acc[w_ax][31]}}, r_integ_acc[w_ax]};
    assign w_ilim38 = $signed({6'd0, r_ilim});

    always_comb begin
        if (r_integ_raw > w_ilim38) begin
            w_integ_clamp = w_ilim38;
        end else if (r_integ_raw < -w_ilim38) begin
            w_integ_clamp = -w_ilim38;
        end else begin
            w_integ_clamp = r_integ_raw;
        end
    end

    always_comb begin
        if (w_drv_full > t_prod'(r_olim)) begin
            w_drv_lim = t_prod'(r_olim);
        end else if (w_drv_full < -t_prod'(r_olim)) begin
            w_drv_lim = -t_prod'(r_olim);
        end else begin
            w_drv_lim = w_drv_full;
        end
    end
    assign w_drive = $signed(w_drv_lim[31:0]);

    // Operand selection for the shared multiplier
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            ST_C0: begin
                w_mul_a = $signed({18'd0, w_olim_s});
                w_mul_b = $signed({17'd0, r_bat});
            end
            ST_C1: begin
                w_mul_a = $signed({18'd0, w_ilim_s});
                w_mul_b = $signed({17'd0, r_bat});
            end
            ST_C2: begin
                w_mul_a = $signed({18'd0, w_ki});
                w_mul_b = $signed({1'b0, w_cfg.integration_step});
            end
            ST_C3: begin
                w_mul_a = $signed({18'd0, w_kp});
                w_mul_b = $signed({17'd0, r_ps});
            end
            ST_C4: begin
                w_mul_a = {{2{r_err[31]}}, r_err};
                w_mul_b = $signed({5'd0, r_kis});
            end
            ST_C5: begin
                w_mul_a = $signed({2'b00, r_tmp});
                w_mul_b = TENTH_B;
            end
            ST_C6: begin
                w_mul_a = $signed({18'd0, w_kd});
                w_mul_b = $signed({17'd0, r_ds});
            end
            ST_C7: begin
                w_mul_a = {{2{r_err[31]}}, r_err};
                w_mul_b = $signed({6'd0, r_gain});
            end
            ST_C8: begin
                w_mul_a = $signed({12'd0, r_g});
                w_mul_b = $signed({1'b0, w_cfg.derivative_factor});
            end
            ST_C10: begin
                w_mul_a = {r_ndiff[32], r_ndiff};
                w_mul_b = $signed({2'b00, r_dg});
            end
            ST_C13: begin
                w_mul_a = r_sum;
                w_mul_b = $signed({17'd0, r_bat});
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = w_in_fire ? (w_axis_ok ? ST_C0 : ST_FIN) : ST_IDLE;
            ST_C0:   n_state = ST_C1;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_C3;
            ST_C3:   n_state = ST_C4;
            ST_C4:   n_state = ST_C5;
            ST_C5:   n_state = ST_C6;
            ST_C6:   n_state = ST_C7;
            ST_C7:   n_state = ST_C8;
            ST_C8:   n_state = ST_C9;
            ST_C9:   n_state = ST_C10;
            ST_C10:  n_state = ST_C11;
            ST_C11:  n_state = ST_C12;
            ST_C12:  n_state = ST_C13;
            ST_C13:  n_state = ST_FIN;
            ST_FIN:  n_state = w_out_room ? ST_IDLE : ST_FIN;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < AXIS_COUNT; k++) begin
                r_integ_acc[k]  <= '0;
                r_prev_drive[k] <= '0;
                r_hist0[k]      <= '0;
                r_hist1[k]      <= '0;
            end
        end else begin
            r_state <= n_state;
            // Load a finished result, or drop the one just taken
            if ((r_state == ST_FIN) && w_out_room) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: if (w_in_fire) begin
                    // Take the word; gain scales only count on roll and pitch
                    r_axis   <= i_axis;
                    r_err    <= i_rate_error;
                    r_rate   <= i_filtered_rate;
                    r_ground <= i_on_ground;
                    r_bat    <= i_battery_scale;
                    r_ps     <= (i_axis < SCALED_AXES) ? i_p_gain_scale : ONE_Q14;
                    r_ds     <= (i_axis < SCALED_AXES) ? i_d_gain_scale : ONE_Q14;
                    r_null   <= !w_axis_ok;
                end
                ST_C0: begin
                    // Negated central difference against the oldest sample
                    r_ndiff <= {r_hist1[w_ax][31], r_hist1[w_ax]} - {r_rate[31], r_rate};
                end
                ST_C1: r_olim <= w_lim_full[31:0];
                ST_C2: begin
                    r_ilim <= w_lim_full[31:0];
                    r_hold <= w_hold;
                end
                ST_C3: r_kis <= w_kis_full[27:0];
                ST_C4: r_tmp <= w_prod[31:0];
                ST_C5: begin
                    r_integ_raw <= w_base + (r_hold ? '0 : $signed(w_delta[37:0]));
                end
                ST_C6: begin
                    r_gain  <= w_gain_full[26:0];
                    r_integ <= $signed(w_integ_clamp[31:0]);
                    r_kd_nz <= (w_kd != '0);
                end
                ST_C7: r_g <= w_g_full[21:0];
                ST_C8: r_p <= sat32(w_p_full);
                ST_C9: begin
                    // Saturate the combined D gain
                    r_dg <= (w_dg_full > INT32_MAX_P) ? '1 : w_dg_full[30:0];
                    r_pi <= {r_p[31], r_p} + {r_integ[31], r_integ};
                end
                ST_C11: r_d <= r_kd_nz ? sat32(w_d_full) : '0;
                ST_C12: r_sum <= {r_pi[32], r_pi} + {{2{r_d[31]}}, r_d};
                ST_FIN: if (w_out_room) begin
                    if (r_null) begin
                        r_out_drive <= '0;
                        r_out_p     <= '0;
                        r_out_i     <= '0;
                        r_out_d     <= '0;
                        r_out_hold  <= 1'b0;
                    end else begin
                        r_out_drive        <= w_drive;
                        r_out_p            <= r_p;
                        r_out_i            <= r_integ;
                        r_out_d            <= r_d;
                        r_out_hold         <= r_hold;
                        r_integ_acc[w_ax]  <= r_integ;
                        r_prev_drive[w_ax] <= w_drive;
                        // Advance the rate history only while D is active
                        if (r_kd_nz) begin
                            r_hist1[w_ax] <= r_hist0[w_ax];
                            r_hist0[w_ax] <= r_rate;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_out_drive;
    assign o_p_part      = r_out_p;
    assign o_i_part      = r_out_i;
    assign o_d_part      = r_out_d;
    assign o_windup_hold = r_out_hold;

endmodule

// File: rtl/rpac_chk.sv
// Port-level checker for the rate PID axis controller, bound to the top level.
// Depends only on the handshake and result ports of the top level.
module rpac_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [31:0]    o_drive,
    input logic signed [31:0]    o_p_part,
    input logic signed [31:0]    o_i_part,
    input logic signed [31:0]    o_d_part,
    input logic                  o_windup_hold
);

    // Come out of reset idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("not idle after reset");

    // One word at a time: drop ready after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after accepting a word");

    // A new result only appears from a busy sequencer
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work in progress");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_drive) &&
            $stable(o_p_part) && $stable(o_i_part) && $stable(o_d_part) &&
            $stable(o_windup_hold))
        else $error("stalled result changed");

endmodule

bind rate_pid_axis_controller rpac_chk u_rpac_chk (.*);

// File: verif/rate_pid_axis_controller_tb.sv
// Self-checking testbench for rate_pid_axis_controller: random and directed words
// are checked against a bit-exact PID predictor. Depends on rpac_pkg and the RTL.
`timescale 1ns / 1ps

module rate_pid_axis_controller_tb;
    import rpac_pkg::*;

    // Run shape
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 24;    // long enough for the sequencer to finish a word
    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 110;
    localparam int MAX_WAIT        = 12;

    localparam logic [1:0]         AX_SPARE = 2'd3;    // axis code with no slot
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
    localparam logic [47:0]        ALL48    = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0]        ALL32    = 32'hFFFF_FFFF;

    // Wide signed type for the predictor: covers every intermediate product
    typedef logic signed [79:0] t_wide;
    localparam t_wide W_MAX = 80'sd2147483647;
    localparam t_wide W_MIN = -80'sd2147483648;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] err;
        logic signed [31:0] rate;
        logic               ground;
        logic [15:0]        bat;
        logic [15:0]        pscale;
        logic [15:0]        dscale;
    } t_rate_word;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [31:0] p_part;
        logic signed [31:0] i_part;
        logic signed [31:0] d_part;
        logic               hold;
    } t_axis_out;

    // Block ports
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_axis          = '0;
    logic signed [31:0]    i_rate_error    = '0;
    logic signed [31:0]    i_filtered_rate = '0;
    logic                  i_on_ground     = 1'b0;
    logic [15:0]           i_battery_scale = '0;
    logic [15:0]           i_p_gain_scale  = '0;
    logic [15:0]           i_d_gain_scale  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic signed [31:0]    o_drive;
    logic signed [31:0]    o_p_part;
    logic signed [31:0]    o_i_part;
    logic signed [31:0]    o_d_part;
    logic                  o_windup_hold;

    // Words waiting to be sent, and axis outputs owed by the block, oldest first
    t_rate_word rate_words_q[$];
    t_axis_out  axis_outputs_q[$];

    // Shadow of the register file, as it stands after reset
    logic [47:0] kp_set   = '0;
    logic [47:0] ki_set   = '0;
    logic [47:0] kd_set   = '0;
    logic [47:0] olim_set = RST_OUT_LIMITS;
    logic [47:0] ilim_set = RST_INTEGRAL_LIMITS;
    logic [31:0] step_set = RST_STEP;
    logic [31:0] dfac_set = RST_DFAC;

    // Shadow of the per-axis state; rate_hist holds the newest sample in slot 0
    logic signed [31:0] integ_acc  [AXIS_COUNT]    = '{default: '0};
    logic signed [31:0] last_drive [AXIS_COUNT]    = '{default: '0};
    logic signed [31:0] rate_hist  [AXIS_COUNT][2] = '{default: '{default: '0}};

    // Stimulus shaping: error sign held over runs of words, a slow random walk
    // of the gyro rate per axis, and a flag that switches all idling off
    logic               push_neg  = 1'b0;
    logic signed [31:0] rate_walk [4] = '{default: '0};
    logic               calm      = 1'b0;

    int         fail_count = 0;
    int         cycles_run = 0;
    int         in_wait    = 0;
    int         out_wait   = 0;
    t_rate_word cur_word   = '0;

    rate_pid_axis_controller DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_axis          (i_axis),
        .i_rate_error    (i_rate_error),
        .i_filtered_rate (i_filtered_rate),
        .i_on_ground     (i_on_ground),
        .i_battery_scale (i_battery_scale),
        .i_p_gain_scale  (i_p_gain_scale),
        .i_d_gain_scale  (i_d_gain_scale),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive         (o_drive),
        .o_p_part        (o_p_part),
        .o_i_part        (o_i_part),
        .o_d_part        (o_d_part),
        .o_windup_hold   (o_windup_hold)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------

    // Add half an LSB, then shift right arithmetically (floor)
    function automatic t_wide rshift_round(input t_wide v, input int sh);
        return (v + (t_wide'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_wide clamp_mag(input t_wide v, input t_wide lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_wide sat_word(input t_wide v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // PID predictor: works out the axis outputs for one word and advances
    // the shadow state exactly as the block does
    // ------------------------------------------------------------------
    function automatic t_axis_out run_rate_pid(input t_rate_word w);
        t_axis_out   r;
        int          ax;
        logic [15:0] kp, ki, kd, ps, ds;
        t_wide       err, rate, olim, ilim, integ, prev, kis, gain, p, d;
        t_wide       g, dg, diff, sum, drive;
        logic        hold;

        r  = '0;
        ax = w.axis;
        // An axis with no slot leaves every field zero and the state alone
        if (ax >= AXIS_LIMIT_I) return r;

        kp   = kp_set[16*ax +: 16];
        ki   = ki_set[16*ax +: 16];
        kd   = kd_set[16*ax +: 16];
        // Gain scales apply to roll and pitch only; yaw runs at unity
        ps   = (w.axis < SCALED_AXES) ? w.pscale : ONE_Q14;
        ds   = (w.axis < SCALED_AXES) ? w.dscale : ONE_Q14;
        err  = w.err;
        rate = w.rate;

        // Both limits follow the battery: Q0.16 x Q2.14 back to Q.16
        olim = rshift_round(t_wide'(olim_set[16*ax +: 16]) * t_wide'(w.bat), LIM_SHIFT);
        ilim = rshift_round(t_wide'(ilim_set[16*ax +: 16]) * t_wide'(w.bat), LIM_SHIFT);

        // Clear on ground, freeze while the last drive sits at the limit and the
        // error pushes further into it
        if (w.ground) integ = '0;
        else integ = integ_acc[ax];
        prev = last_drive[ax];
        hold = (prev >= olim && err > 0) || (prev <= -olim && err < 0);
        if (!hold) begin
            kis   = rshift_round(t_wide'(ki) * t_wide'(step_set), 20);
            integ = integ + rshift_round(err * kis, 24);
        end
        integ         = clamp_mag(integ, ilim);
        integ_acc[ax] = integ[31:0];

        gain = rshift_round(t_wide'(kp) * t_wide'(ps) * t_wide'(TENTH_Q20), 22);
        p    = sat_word(rshift_round(err * gain, 24));

        // D term and its history move only while kd is non-zero
        d = '0;
        if (kd != '0) begin
            g    = rshift_round(t_wide'(kd) * t_wide'(ds), 10);
            dg   = rshift_round(g * t_wide'(dfac_set), 16);
            if (dg > W_MAX) dg = W_MAX;
            diff = rate - t_wide'(rate_hist[ax][1]);
            d    = sat_word(rshift_round(-(diff * dg), 17));
            rate_hist[ax][1] = rate_hist[ax][0];
            rate_hist[ax][0] = w.rate;
        end

        sum   = p + integ + d;
        drive = clamp_mag(rshift_round(sum * t_wide'(w.bat), 14), olim);
        last_drive[ax] = drive[31:0];

        r.drive  = drive[31:0];
        r.p_part = p[31:0];
        r.i_part = integ[31:0];
        r.d_part = d[31:0];
        r.hold   = hold;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------

    // Cycles to idle before the next word on either side
    function automatic int draw_wait();
        if (calm) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Q2.14 scale: mostly near unity, sometimes the extremes or any pattern
    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(8192, 24576));
        endcase
    endfunction

    function automatic logic [15:0] pick_slot();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom());
            default: return 16'($urandom_range(0, 16'h2000));
        endcase
    endfunction

    function automatic logic [47:0] pick_slots();
        return {pick_slot(), pick_slot(), pick_slot()};
    endfunction

    function automatic logic [31:0] pick_word32(input logic [31:0] typical);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL32;
            2:       return $urandom();
            default: return $urandom_range(typical / 4, typical * 4);
        endcase
    endfunction

    // Mostly plausible flight data: an error of one sign held over runs of
    // words (drives the integral into its limits and the windup freeze) and a
    // slowly wandering rate; the rest is extremes and arbitrary patterns
    function automatic t_rate_word make_rate_word();
        t_rate_word         w;
        int                 ax;
        int                 dr;
        logic signed [31:0] mag;

        ax     = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2);
        w.axis = 2'(ax);

        if ($urandom_range(0, 39) == 0) push_neg = ~push_neg;
        mag = $urandom_range(0, 32'h0008_0000);
        case ($urandom_range(0, 11))
            0:       w.err = $urandom();
            1:       w.err = S32_MAX;
            2:       w.err = S32_MIN;
            3:       w.err = '0;
            default: w.err = push_neg ? -mag : mag;
        endcase

        dr = $urandom_range(0, 8192) - 4096;
        rate_walk[ax] = rate_walk[ax] + dr;
        case ($urandom_range(0, 15))
            0:       w.rate = $urandom();
            1:       w.rate = S32_MAX;
            2:       w.rate = S32_MIN;
            default: w.rate = rate_walk[ax];
        endcase

        w.ground = ($urandom_range(0, 9) == 0);
        w.bat    = pick_scale();
        w.pscale = pick_scale();
        w.dscale = pick_scale();
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            log_failure($sformatf("%s: expected %0d (0x%08h), got %0d (0x%08h)",
                                  name, $signed(want), want, $signed(got), got));
    endtask

    task automatic queue_word(input logic [1:0] axis, input logic signed [31:0] err,
                              input logic signed [31:0] rate, input logic ground,
                              input logic [15:0] bat, input logic [15:0] ps,
                              input logic [15:0] ds);
        t_rate_word w;
        w = '{axis: axis, err: err, rate: rate, ground: ground,
              bat: bat, pscale: ps, dscale: ds};
        rate_words_q.push_back(w);
    endtask

    // One register write, one cycle of enable; keep the shadow in step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_KP:   kp_set   = val;
            CFG_KI:   ki_set   = val;
            CFG_KD:   kd_set   = val;
            CFG_OLIM: olim_set = val;
            CFG_ILIM: ilim_set = val;
            CFG_STEP: step_set = val[31:0];
            CFG_DFAC: dfac_set = val[31:0];
            default:  ;
        endcase
    endtask

    task automatic program_regs(input logic [47:0] kp, ki, kd, olim, ilim,
                                input logic [31:0] stp, dfac);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_OLIM, olim);
        write_reg(CFG_ILIM, ilim);
        write_reg(CFG_STEP, {16'h0, stp});
        write_reg(CFG_DFAC, {16'h0, dfac});
    endtask

    // Hold until no word is queued or in flight and no axis output is owed,
    // then let the sequencer run out. Sampled on the falling edge so that the
    // driver and monitor have settled for the cycle.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (rate_words_q.size() != 0 || i_in_valid || axis_outputs_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: predict each word as it is accepted, then present the
    // next one after its drawn idle gap
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                axis_outputs_q.push_back(run_rate_pid(cur_word));
            if (!i_in_valid || o_in_ready) begin
                if (in_wait != 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (rate_words_q.size() != 0) begin
                    cur_word         = rate_words_q.pop_front();
                    i_axis          <= cur_word.axis;
                    i_rate_error    <= cur_word.err;
                    i_filtered_rate <= cur_word.rate;
                    i_on_ground     <= cur_word.ground;
                    i_battery_scale <= cur_word.bat;
                    i_p_gain_scale  <= cur_word.pscale;
                    i_d_gain_scale  <= cur_word.dscale;
                    i_in_valid      <= 1'b1;
                    in_wait = draw_wait();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: compare every accepted word with the oldest owed one,
    // then drop ready for a drawn number of cycles
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_axis_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (axis_outputs_q.size() == 0) begin
                    log_failure("output word with nothing owed");
                end else begin
                    want = axis_outputs_q.pop_front();
                    check_field("drive", want.drive, o_drive);
                    check_field("p_part", want.p_part, o_p_part);
                    check_field("i_part", want.i_part, o_i_part);
                    check_field("d_part", want.d_part, o_d_part);
                    check_field("windup_hold", {31'b0, want.hold}, {31'b0, o_windup_hold});
                end
                out_wait = draw_wait();
            end
            if (out_wait != 0) begin
                out_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Switch idling off now and then, for stretches of back-to-back words
    always @(posedge i_clk) begin
        if ($urandom_range(0, 149) == 0) calm <= ~calm;
    end

    // Watchdog
    initial begin
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings straight out of reset: zero gains, so every term stays zero
        queue_word(AX_ROLL,  32'sd65536,  32'sd1000, 1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        queue_word(AX_PITCH, -32'sd65536, 32'sd0,    1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        queue_word(AX_YAW,   S32_MAX,     S32_MIN,   1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // Moderate gains; yaw with kd of zero so its D term is disabled
        program_regs(48'h1000_1800_2000, 48'h1000_1000_1000, 48'h0000_0800_0400,
                     48'h8000_8000_8000, 48'h4000_4000_4000, RST_STEP * 4, RST_DFAC);
        queue_word(AX_ROLL,  32'sd65536,  32'sd0,     1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        queue_word(AX_PITCH, -32'sd65536, 32'sd1000,  1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        // yaw ignores its gain scales
        queue_word(AX_YAW,   32'sd32768,  -32'sd5000, 1'b0, ONE_Q14, 16'hFFFF, 16'h0000);
        // axis with no slot
        queue_word(AX_SPARE, S32_MAX,     S32_MAX,    1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        queue_word(AX_ROLL,  32'sd65536,  32'sd10,    1'b1, ONE_Q14, ONE_Q14, ONE_Q14);
        // zero battery: both limits collapse to zero
        queue_word(AX_PITCH, 32'sd65536,  32'sd10,    1'b0, 16'h0000, ONE_Q14, ONE_Q14);
        // drive into the limit, then push further to freeze the integral
        queue_word(AX_ROLL,  S32_MAX,     S32_MAX,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_ROLL,  S32_MAX,     S32_MAX,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_ROLL,  S32_MIN,     S32_MIN,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_ROLL,  S32_MIN,     S32_MIN,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_PITCH, 32'sd0,      32'sd0,     1'b0, 16'h0001, 16'h0000, 16'h0000);
        queue_word(AX_YAW,   -32'sd1,     32'sd1,     1'b1, 16'hFFFF, ONE_Q14, ONE_Q14);
        wait_drained();

        // Everything at full scale: P and D overflow, the D gain saturates
        program_regs(ALL48, ALL48, ALL48, ALL48, ALL48, ALL32, ALL32);
        queue_word(AX_ROLL,  S32_MAX,     S32_MIN,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_ROLL,  S32_MIN,     S32_MAX,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_PITCH, S32_MIN,     S32_MIN,    1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_YAW,   S32_MAX,     32'sd0,     1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_SPARE, S32_MIN,     S32_MIN,    1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(AX_PITCH, 32'sd1,      -32'sd1,    1'b0, 16'h0000, ONE_Q14, ONE_Q14);
        queue_word(AX_YAW,   32'sd65536,  32'sd65536, 1'b1, ONE_Q14, ONE_Q14, ONE_Q14);
        queue_word(AX_ROLL,  -32'sd65536, 32'sd0,     1'b0, ONE_Q14, ONE_Q14, ONE_Q14);
        wait_drained();

        // Random phases, each under fresh settings; the first two pin the extremes.
        // The sender pauses at every boundary until all owed words are back.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0)
                program_regs('0, '0, '0, '0, '0, '0, '0);
            else if (ph == 1)
                program_regs(ALL48, ALL48, ALL48, ALL48, ALL48, ALL32, ALL32);
            else
                program_regs(pick_slots(), pick_slots(), pick_slots(), pick_slots(),
                             pick_slots(), pick_word32(RST_STEP), pick_word32(RST_DFAC));
            repeat (WORDS_PER_PHASE) rate_words_q.push_back(make_rate_word());
            wait_drained();
        end

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
